FILE: rtl/hex_tag_line_parser_top_macros.svh
// assertion macros for the hex tag line parser
// used by hex_tag_line_parser_top only
`ifndef HEX_TAG_LINE_PARSER_TOP_MACROS_SVH
`define HEX_TAG_LINE_PARSER_TOP_MACROS_SVH

// condition on this edge implies consequence on this edge
`define HTLP_ASSERT_NOW(label, clock, reset, cond, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
    else $error(msg);

// condition on this edge implies consequence on the next edge
`define HTLP_ASSERT_NEXT(label, clock, reset, cond, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/htlp_pkg.sv
// shared types, codes and character helpers for the hex tag line parser
// no dependencies
`default_nettype none

package htlp_pkg;

  localparam int unsigned MAX_CHARS = 15;
  localparam int unsigned CNT_W     = 4;

  // input modes
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TAKE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // phase codes as seen on the output
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_RECV = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;
  localparam logic [1:0] PHASE_ERR  = 2'd3;

  // tag kinds
  localparam logic [1:0] KIND_INVALID    = 2'd0;
  localparam logic [1:0] KIND_INCOMPLETE = 2'd1;
  localparam logic [1:0] KIND_EMERGENCY  = 2'd2;
  localparam logic [1:0] KIND_NORMAL     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_LEN  = 2'd0;
  localparam logic [1:0] REG_EMERG_LO = 2'd1;
  localparam logic [1:0] REG_EMERG_HI = 2'd2;
  localparam logic [1:0] REG_EMERG_LEN = 2'd3;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_NL = 8'h0a;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RECV = 4'b0010,
    ST_DONE = 4'b0100,
    ST_ERR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_len;
    logic [63:0]      emerg_lo;
    logic [63:0]      emerg_hi;
    logic [CNT_W-1:0] emerg_len;
  } cfg_t;

  // packed so that phase lands in the lowest bits of tdata
  typedef struct packed {
    logic             take_ok;
    logic [CNT_W-1:0] char_count;
    logic             tag_waiting;
    logic [1:0]       tag_kind;
    logic [1:0]       phase;
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= CH_0) && (b <= CH_9)) || ((b >= CH_UA) && (b <= CH_UF)) ||
           ((b >= CH_LA) && (b <= CH_LF));
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    code = PHASE_IDLE;
    unique case (ph)
      ST_IDLE: code = PHASE_IDLE;
      ST_RECV: code = PHASE_RECV;
      ST_DONE: code = PHASE_DONE;
      ST_ERR:  code = PHASE_ERR;
      default: code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/htlp_cfg.sv
// configuration registers of the hex tag line parser
// depends on htlp_pkg
`default_nettype none

module htlp_cfg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  output htlp_pkg::cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len   <= htlp_pkg::CNT_W'(10);
      cfg.emerg_lo  <= '0;
      cfg.emerg_hi  <= '0;
      cfg.emerg_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htlp_pkg::REG_MIN_LEN:   cfg.min_len   <= cfg_data[htlp_pkg::CNT_W-1:0];
        htlp_pkg::REG_EMERG_LO:  cfg.emerg_lo  <= cfg_data;
        htlp_pkg::REG_EMERG_HI:  cfg.emerg_hi  <= cfg_data;
        htlp_pkg::REG_EMERG_LEN: cfg.emerg_len <= cfg_data[htlp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/htlp_in_stage.sv
// input register of the hex tag line parser, holds one item ahead of the core
// depends on htlp_pkg
`default_nettype none

module htlp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,
  input  wire logic [1:0]      s_tuser,
  output logic                 item_valid,
  output htlp_pkg::item_t      item,
  input  wire logic            item_pop
);

  logic full;

  assign s_tready   = !full || item_pop;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tready) begin
      full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode    <= s_tuser;
      item.rx_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/htlp_core.sv
// parser state, per-item next-state logic and result register
// depends on htlp_pkg
`default_nettype none

module htlp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire htlp_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire htlp_pkg::item_t item,
  output logic                 item_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output htlp_pkg::result_t    res
);

  htlp_pkg::phase_t             phase, phase_next;
  logic [htlp_pkg::CNT_W-1:0]   count, count_next;
  logic                         match, match_next;
  logic [1:0]                   kind, kind_next;
  logic                         ready, ready_next;
  logic                         take_ok;

  logic [127:0] emerg_all;
  logic [7:0]   emerg_char;
  logic         hex;
  logic         term;
  logic         char_hit;

  assign item_pop  = item_valid && (!m_tvalid || m_tready);
  assign emerg_all = {cfg.emerg_hi, cfg.emerg_lo};
  assign emerg_char = emerg_all[{count, 3'b000} +: 8];
  assign hex       = htlp_pkg::is_hex(item.rx_byte);
  assign term      = (item.rx_byte == htlp_pkg::CH_CR) || (item.rx_byte == htlp_pkg::CH_NL);
  assign char_hit  = (count < cfg.emerg_len) && (emerg_char == item.rx_byte);

  always_comb begin
    phase_next = phase;
    count_next = count;
    match_next = match;
    kind_next  = kind;
    ready_next = ready;
    take_ok    = 1'b0;
    case (item.mode)
      htlp_pkg::MODE_BYTE: begin
        unique case (phase)
          htlp_pkg::ST_IDLE: begin
            if (hex) begin
              phase_next = htlp_pkg::ST_RECV;
              count_next = count + 1'b1;
              match_next = match && char_hit;
            end
          end
          htlp_pkg::ST_RECV: begin
            if (hex) begin
              if (count < htlp_pkg::CNT_W'(htlp_pkg::MAX_CHARS)) begin
                count_next = count + 1'b1;
                match_next = match && char_hit;
              end else begin
                phase_next = htlp_pkg::ST_ERR;
                kind_next  = htlp_pkg::KIND_INVALID;
              end
            end else if (term) begin
              if (count >= cfg.min_len) begin
                phase_next = htlp_pkg::ST_DONE;
                if (match && (cfg.emerg_len != '0) && (count == cfg.emerg_len)) begin
                  kind_next = htlp_pkg::KIND_EMERGENCY;
                end else begin
                  kind_next = htlp_pkg::KIND_NORMAL;
                end
              end else if (count != '0) begin
                phase_next = htlp_pkg::ST_ERR;
                kind_next  = htlp_pkg::KIND_INCOMPLETE;
              end else begin
                phase_next = htlp_pkg::ST_IDLE;
              end
              ready_next = 1'b1;
            end else begin
              phase_next = htlp_pkg::ST_ERR;
              kind_next  = htlp_pkg::KIND_INVALID;
            end
          end
          htlp_pkg::ST_DONE, htlp_pkg::ST_ERR: ;
          default: ;
        endcase
      end
      htlp_pkg::MODE_TAKE: begin
        if (ready) begin
          phase_next = htlp_pkg::ST_IDLE;
          count_next = '0;
          match_next = 1'b1;
          kind_next  = htlp_pkg::KIND_INVALID;
          ready_next = 1'b0;
          take_ok    = 1'b1;
        end
      end
      htlp_pkg::MODE_RESET: begin
        phase_next = htlp_pkg::ST_IDLE;
        count_next = '0;
        match_next = 1'b1;
        kind_next  = htlp_pkg::KIND_INVALID;
        ready_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= htlp_pkg::ST_IDLE;
      count    <= '0;
      match    <= 1'b1;
      kind     <= htlp_pkg::KIND_INVALID;
      ready    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (item_pop) begin
        phase <= phase_next;
        count <= count_next;
        match <= match_next;
        kind  <= kind_next;
        ready <= ready_next;
      end
      if (item_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result shows the state after the item
  always_ff @(posedge clk) begin
    if (item_pop) begin
      res.phase       <= htlp_pkg::phase_code(phase_next);
      res.tag_kind    <= kind_next;
      res.tag_waiting <= ready_next;
      res.char_count  <= count_next;
      res.take_ok     <= take_ok;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hex_tag_line_parser_top.sv
// top level of the hex tag line parser: config registers, input register, parser core
// depends on htlp_pkg, htlp_cfg, htlp_in_stage, htlp_core and the macros header
//
//   channel  | signals                          | contents
//   s (in)   | s_tvalid s_tready s_tdata s_tuser| rx_byte in tdata, mode in tuser
//   m (out)  | m_tvalid m_tready m_tdata        | phase, kind, waiting, count, take_ok
//   cfg      | cfg_we cfg_index cfg_data        | register write, no read-back
//
// one item per cycle if m_tready keeps up; each popped item gives a registered result
// the input register takes one more item while a result waits on m_tready
// the state update is compares on count and byte, one increment and a 16-way byte select
// rst is synchronous and clears parser state and configuration to defaults
`default_nettype none

`include "hex_tag_line_parser_top_macros.svh"

module hex_tag_line_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [1:0] phase, [3:2] tag_kind, [4] tag_waiting,
                                      // [8:5] char_count, [9] take_ok, rest zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  htlp_pkg::cfg_t    cfg;
  htlp_pkg::item_t   item;
  htlp_pkg::result_t res;
  logic              item_valid;
  logic              item_pop;

  logic              out_take_ok;
  logic              out_cleared;
  logic              out_waiting;
  logic              out_wait_ok;
  logic              out_recv;
  logic              in_stalled;

  htlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htlp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  htlp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res        (res)
  );

  assign m_tdata = {6'b000000, res};

  assign out_take_ok = m_tvalid && res.take_ok;
  assign out_cleared = (res.phase == htlp_pkg::PHASE_IDLE) && (res.char_count == '0) &&
                       !res.tag_waiting;
  assign out_waiting = m_tvalid && res.tag_waiting;
  assign out_wait_ok = (res.phase == htlp_pkg::PHASE_DONE) ||
                       ((res.phase == htlp_pkg::PHASE_ERR) &&
                        (res.tag_kind == htlp_pkg::KIND_INCOMPLETE));
  assign out_recv    = m_tvalid && (res.phase == htlp_pkg::PHASE_RECV);
  assign in_stalled  = item_valid && m_tvalid && !m_tready && !(s_tvalid && s_tready);

  // a successful take leaves the parser fully cleared
  `HTLP_ASSERT_NOW(a_take_clears, clk, rst, out_take_ok, out_cleared, "take not cleared")

  // a waiting result is either a finished tag or a short-line error
  `HTLP_ASSERT_NOW(a_ready_phase, clk, rst, out_waiting, out_wait_ok, "waiting in wrong phase")

  // reception always holds at least one character
  `HTLP_ASSERT_NOW(a_recv_count, clk, rst, out_recv, res.char_count != '0, "empty reception")

  // a held item with a stalled result blocks the input
  `HTLP_ASSERT_NEXT(a_stall_blocks, clk, rst, in_stalled, item_valid, "held item lost")

endmodule

`default_nettype wire

FILE: verif/hex_tag_line_parser_top_test.sv
// self-checking bench for hex_tag_line_parser_top: queue-fed stream driver, result monitor
// and a cycle-free model of the parser that predicts every result item
// depends on htlp_pkg and the hex_tag_line_parser_top rtl
module hex_tag_line_parser_top_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] rx;
    bit         drain_first;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] rx_byte
  logic [1:0]  s_tuser = '0;    // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] phase, [3:2] tag_kind, [4] tag_waiting,
                                // [8:5] char_count, [9] take_ok
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  hex_tag_line_parser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // configuration copy, reset values
  logic [3:0]  min_len_cfg = 4'd10;
  logic [63:0] alarm_lo_cfg = '0;
  logic [63:0] alarm_hi_cfg = '0;
  logic [3:0]  alarm_len_cfg = '0;

  // parser state copy
  logic [1:0] parse_phase = htlp_pkg::PHASE_IDLE;
  logic [3:0] parse_count = '0;
  logic       parse_match = 1'b1;
  logic [1:0] parse_kind = htlp_pkg::KIND_INVALID;
  logic       parse_ready = 1'b0;

  stream_item_t      stream_items[$];
  htlp_pkg::result_t expected_status[$];

  int  queued_total = 0;
  int  accepted_items = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_next = 1'b0;
  int  normal_lines = 0;
  int  emergency_lines = 0;
  int  short_lines = 0;
  int  invalid_lines = 0;
  int  takes_ok = 0;

  function automatic bit hex_char(input logic [7:0] b);
    return (b >= htlp_pkg::CH_0 && b <= htlp_pkg::CH_9) ||
           (b >= htlp_pkg::CH_UA && b <= htlp_pkg::CH_UF) ||
           (b >= htlp_pkg::CH_LA && b <= htlp_pkg::CH_LF);
  endfunction

  function automatic logic [7:0] alarm_char(input logic [3:0] idx);
    if (idx < 4'd8)
      return alarm_lo_cfg[8*idx +: 8];
    return alarm_hi_cfg[8*(idx-8) +: 8];
  endfunction

  function automatic void clear_parser();
    parse_phase = htlp_pkg::PHASE_IDLE;
    parse_count = '0;
    parse_match = 1'b1;
    parse_kind  = htlp_pkg::KIND_INVALID;
    parse_ready = 1'b0;
  endfunction

  // running compare against the emergency tag, one character at a time
  function automatic void add_char(input logic [7:0] b);
    if (!(parse_count < alarm_len_cfg && alarm_char(parse_count) == b))
      parse_match = 1'b0;
    parse_count = parse_count + 4'd1;
  endfunction

  function automatic htlp_pkg::result_t advance_parser(input logic [1:0] mode,
                                                       input logic [7:0] b);
    htlp_pkg::result_t r;
    logic              took;
    took = 1'b0;
    case (mode)
      htlp_pkg::MODE_BYTE: begin
        if (parse_phase == htlp_pkg::PHASE_IDLE) begin
          if (hex_char(b)) begin
            parse_phase = htlp_pkg::PHASE_RECV;
            add_char(b);
          end
        end else if (parse_phase == htlp_pkg::PHASE_RECV) begin
          if (hex_char(b)) begin
            if (parse_count < htlp_pkg::MAX_CHARS) begin
              add_char(b);
            end else begin
              parse_phase = htlp_pkg::PHASE_ERR;
              parse_kind  = htlp_pkg::KIND_INVALID;
              invalid_lines++;
            end
          end else if (b == htlp_pkg::CH_CR || b == htlp_pkg::CH_NL) begin
            if (parse_count >= min_len_cfg) begin
              parse_phase = htlp_pkg::PHASE_DONE;
              if (parse_match && alarm_len_cfg != 0 && parse_count == alarm_len_cfg) begin
                parse_kind = htlp_pkg::KIND_EMERGENCY;
                emergency_lines++;
              end else begin
                parse_kind = htlp_pkg::KIND_NORMAL;
                normal_lines++;
              end
            end else if (parse_count > 0) begin
              parse_phase = htlp_pkg::PHASE_ERR;
              parse_kind  = htlp_pkg::KIND_INCOMPLETE;
              short_lines++;
            end else begin
              parse_phase = htlp_pkg::PHASE_IDLE;
            end
            parse_ready = 1'b1;
          end else begin
            parse_phase = htlp_pkg::PHASE_ERR;
            parse_kind  = htlp_pkg::KIND_INVALID;
            invalid_lines++;
          end
        end
      end
      htlp_pkg::MODE_TAKE: begin
        if (parse_ready) begin
          clear_parser();
          took = 1'b1;
          takes_ok++;
        end
      end
      htlp_pkg::MODE_RESET: clear_parser();
      default: ;
    endcase
    r.phase       = parse_phase;
    r.tag_kind    = parse_kind;
    r.tag_waiting = parse_ready;
    r.char_count  = parse_count;
    r.take_ok     = took;
    return r;
  endfunction

  // driver: a valid item stays up until taken
  always @(posedge clk) begin
    stream_item_t nxt;
    logic         present;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      present = 1'b0;
      if (s_tvalid && s_tready) begin
        expected_status.push_back(advance_parser(s_tuser, s_tdata));
        accepted_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (stream_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          if (!stream_items[0].drain_first || expected_status.size() == 0) begin
            nxt = stream_items.pop_front();
            s_tdata <= nxt.rx;
            s_tuser <= nxt.mode;
            present = 1'b1;
          end
        end
        s_tvalid <= present;
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("result %0d: %s expected %0h, got %0h", results_seen, what, want, got);
  endtask

  // monitor
  always @(posedge clk) begin
    htlp_pkg::result_t want;
    htlp_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = htlp_pkg::result_t'(m_tdata[9:0]);
      if (expected_status.size() == 0) begin
        flag_mismatch("unexpected item", '0, m_tdata);
      end else begin
        want = expected_status.pop_front();
        if (got.phase !== want.phase)
          flag_mismatch("phase", 16'(want.phase), 16'(got.phase));
        if (got.tag_kind !== want.tag_kind)
          flag_mismatch("tag_kind", 16'(want.tag_kind), 16'(got.tag_kind));
        if (got.tag_waiting !== want.tag_waiting)
          flag_mismatch("tag_waiting", 16'(want.tag_waiting), 16'(got.tag_waiting));
        if (got.char_count !== want.char_count)
          flag_mismatch("char_count", 16'(want.char_count), 16'(got.char_count));
        if (got.take_ok !== want.take_ok)
          flag_mismatch("take_ok", 16'(want.take_ok), 16'(got.take_ok));
        if (m_tdata[15:10] !== '0)
          flag_mismatch("pad bits", '0, 16'(m_tdata[15:10]));
      end
      results_seen++;
    end
  end

  task automatic queue_item(input logic [1:0] mode, input logic [7:0] rx);
    stream_item_t it;
    it.mode = mode;
    it.rx = rx;
    it.drain_first = hold_next;
    hold_next = 1'b0;
    stream_items.push_back(it);
    queued_total++;
  endtask

  function automatic logic [7:0] any_hex();
    case ($urandom_range(2))
      0:       return 8'(htlp_pkg::CH_0 + $urandom_range(9));
      1:       return 8'(htlp_pkg::CH_UA + $urandom_range(5));
      default: return 8'(htlp_pkg::CH_LA + $urandom_range(5));
    endcase
  endfunction

  // neither hex nor a line end; half come from a list of eight, six of them next to a hex range
  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(7))
        0:       b = 8'h2f;
        1:       b = 8'h3a;
        2:       b = 8'h40;
        3:       b = 8'h47;
        4:       b = 8'h60;
        5:       b = 8'h67;
        6:       b = 8'h00;
        default: b = 8'hff;
      endcase
    end else begin
      do b = 8'($urandom_range(255));
      while (hex_char(b) || b == htlp_pkg::CH_CR || b == htlp_pkg::CH_NL);
    end
    return b;
  endfunction

  function automatic logic [63:0] hex_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = any_hex();
    return w;
  endfunction

  // one line with random content: mostly well formed, some broken or left open
  task automatic queue_line();
    logic [7:0] body[$];
    int         n;
    int         pick;
    if ($urandom_range(29) == 0)
      hold_next = 1'b1;
    if ($urandom_range(4) == 0)
      queue_item(htlp_pkg::MODE_BYTE, 8'($urandom_range(255)));
    if ($urandom_range(19) == 0)
      queue_item(MODE_UNUSED, 8'($urandom_range(255)));
    if (alarm_len_cfg != 0 && $urandom_range(99) < 35) begin
      for (int i = 0; i < alarm_len_cfg; i++)
        body.push_back(alarm_char(4'(i)));
      case ($urandom_range(3))
        0: body[$urandom_range(body.size() - 1)] = any_hex();
        1: begin
          if (body.size() < htlp_pkg::MAX_CHARS)
            body.push_back(any_hex());
          else
            void'(body.pop_back());
        end
        default: ;
      endcase
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(16, 17) : $urandom_range(1, 15);
      repeat (n) body.push_back(any_hex());
    end
    foreach (body[i])
      queue_item(htlp_pkg::MODE_BYTE, body[i]);
    pick = $urandom_range(19);
    if (pick < 17)
      queue_item(htlp_pkg::MODE_BYTE, $urandom_range(1) ? htlp_pkg::CH_CR : htlp_pkg::CH_NL);
    else if (pick < 19)
      queue_item(htlp_pkg::MODE_BYTE, bad_byte());
    if ($urandom_range(6) == 0)
      queue_item(htlp_pkg::MODE_BYTE, 8'($urandom_range(255)));
    pick = $urandom_range(19);
    if (pick < 14) begin
      queue_item(htlp_pkg::MODE_TAKE, 8'($urandom_range(255)));
    end else if (pick < 17) begin
      queue_item(htlp_pkg::MODE_RESET, 8'($urandom_range(255)));
    end else if (pick < 19) begin
      queue_item(htlp_pkg::MODE_TAKE, 8'($urandom_range(255)));
      queue_item(htlp_pkg::MODE_RESET, 8'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      htlp_pkg::REG_MIN_LEN:   min_len_cfg = val[3:0];
      htlp_pkg::REG_EMERG_LO:  alarm_lo_cfg = val;
      htlp_pkg::REG_EMERG_HI:  alarm_hi_cfg = val;
      htlp_pkg::REG_EMERG_LEN: alarm_len_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [3:0] min_len, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [3:0] alarm_len);
    write_reg(htlp_pkg::REG_MIN_LEN, 64'(min_len));
    write_reg(htlp_pkg::REG_EMERG_LO, lo);
    write_reg(htlp_pkg::REG_EMERG_HI, hi);
    write_reg(htlp_pkg::REG_EMERG_LEN, 64'(alarm_len));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_items != queued_total || expected_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 80;

    // emergency tag "A1f", three characters make a tag
    set_regs(4'd3, 64'h0000_0000_0066_3141, 64'h0, 4'd3);
    queue_item(htlp_pkg::MODE_TAKE, 8'h00);     // nothing ready
    queue_item(MODE_UNUSED, 8'hff);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_CR);     // line end while idle
    queue_item(htlp_pkg::MODE_BYTE, 8'h7a);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_UA);
    queue_item(htlp_pkg::MODE_BYTE, 8'h31);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_LF);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_CR);     // emergency
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_UF);     // ignored while complete
    hold_next = 1'b1;
    queue_item(htlp_pkg::MODE_TAKE, 8'hff);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_0);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_NL);     // short line
    queue_item(htlp_pkg::MODE_TAKE, 8'h00);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_9);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_UF);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_LA);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_NL);     // normal
    queue_item(htlp_pkg::MODE_TAKE, 8'h00);
    queue_item(htlp_pkg::MODE_BYTE, htlp_pkg::CH_UA);
    queue_item(htlp_pkg::MODE_BYTE, 8'h31);
    queue_item(htlp_pkg::MODE_BYTE, 8'h67);     // bad character
    queue_item(htlp_pkg::MODE_TAKE, 8'h00);     // refused, tag not ready
    queue_item(htlp_pkg::MODE_RESET, 8'hff);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 80;
        recv_idle_pct = 7;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_regs(4'd1, hex_word(), hex_word(), 4'd15);
        1: set_regs(4'd15, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 4'd0);
        2: set_regs(4'd0, hex_word(), 64'h0, 4'd1);
        3: set_regs(4'($urandom_range(1, 15)), hex_word(), hex_word(),
                    4'($urandom_range(1, 15)));
        4: set_regs(4'd4, hex_word(), 64'hffff_ffff_ffff_ffff, 4'd8);
        default: set_regs(4'($urandom_range(15)), hex_word(), hex_word(),
                          4'($urandom_range(15)));
      endcase
      phase_start = queued_total;
      while (queued_total - phase_start < 60)
        queue_line();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("ran %0d items through 7 register settings: %0d normal, %0d emergency tags,",
             accepted_items, normal_lines, emergency_lines);
    $display("%0d short and %0d invalid lines, %0d tags taken, %0d results checked",
             short_lines, invalid_lines, takes_ok, results_seen);
    if (mismatch_count == 0 && expected_status.size() == 0)
      $display("hex_tag_line_parser_top: match");
    else
      $display("hex_tag_line_parser_top: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("timed out with %0d results outstanding", expected_status.size());
    $display("hex_tag_line_parser_top: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/htlp_pkg.sv
rtl/htlp_cfg.sv
rtl/htlp_in_stage.sv
rtl/htlp_core.sv
rtl/hex_tag_line_parser_top.sv
verif/hex_tag_line_parser_top_test.sv
